FILE: rtl/core/mini_language_tokenizer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the tokenizer's port checker (mlt_checker).
// Both sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MINI_LANGUAGE_TOKENIZER_MACROS_SVH
`define MINI_LANGUAGE_TOKENIZER_MACROS_SVH

// Same-cycle implication.
`define MLT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MLT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mlt_pkg.sv
// ----------------------------------------------------------------------------
// mlt_pkg
// Shared types and constants of the line tokenizer: token codes, the
// command that travels from the scanner to the emitter, and the text
// buffer write port.
// ----------------------------------------------------------------------------
package mlt_pkg;

    localparam int MAX_TOKEN_CHARS = 32;
    localparam int IDX_W           = $clog2(MAX_TOKEN_CHARS);
    localparam int LEN_W           = $clog2(MAX_TOKEN_CHARS + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    // queued text commands plus the one being emitted
    localparam int TXT_CNT_W   = $clog2(QUEUE_DEPTH + 2);

    localparam int TOK_W = 5;

    localparam logic [TOK_W-1:0] TOK_STRING   = 5'd0;
    localparam logic [TOK_W-1:0] TOK_NUMBER   = 5'd1;
    localparam logic [TOK_W-1:0] TOK_PRINT    = 5'd2;
    localparam logic [TOK_W-1:0] TOK_VAR      = 5'd3;
    localparam logic [TOK_W-1:0] TOK_IF       = 5'd4;
    localparam logic [TOK_W-1:0] TOK_EQUALITY = 5'd5;
    localparam logic [TOK_W-1:0] TOK_RECEIVES = 5'd6;
    localparam logic [TOK_W-1:0] TOK_PLUS     = 5'd7;
    localparam logic [TOK_W-1:0] TOK_MINUS    = 5'd8;
    localparam logic [TOK_W-1:0] TOK_MUL      = 5'd9;
    localparam logic [TOK_W-1:0] TOK_DIV      = 5'd10;
    localparam logic [TOK_W-1:0] TOK_LPAREN   = 5'd11;
    localparam logic [TOK_W-1:0] TOK_RPAREN   = 5'd12;
    localparam logic [TOK_W-1:0] TOK_SEMI     = 5'd13;
    localparam logic [TOK_W-1:0] TOK_COLON    = 5'd14;
    localparam logic [TOK_W-1:0] TOK_EOL      = 5'd15;
    localparam logic [TOK_W-1:0] TOK_ERROR    = 5'd16;

    // One unit of work for the emitter. A text command plays out the
    // buffer (len chars, or one empty result when len is zero); otherwise
    // the command is a single result taken from its own fields.
    typedef struct packed {
        logic             is_text;
        logic [TOK_W-1:0] kind;
        logic [7:0]       ch;
        logic             has_char;
        logic             token_last;
        logic             run_last;
        logic             ovf;
        logic [LEN_W-1:0] len;
    } cmd_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [7:0]       data;
    } mem_wr_t;

endpackage

FILE: rtl/core/mlt_queue.sv
// ----------------------------------------------------------------------------
// mlt_queue
// Short command FIFO between the scanner and the emitter.
// ----------------------------------------------------------------------------
module mlt_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mlt_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output mlt_pkg::cmd_t head,
    output logic          empty
);
    import mlt_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + QPTR_W'(1);
        return r;
    endfunction

    assign full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: rtl/core/mlt_front.sv
// ----------------------------------------------------------------------------
// mlt_front
// Scanner: takes bytes, tracks the scan mode and token length, writes
// token characters to the text buffer and queues emit commands.
// ----------------------------------------------------------------------------
module mlt_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [7:0]      byte_value,
    input  logic            line_end,
    output logic            push,
    output mlt_pkg::cmd_t   push_cmd,
    input  logic            q_full,
    input  logic            text_done,
    output mlt_pkg::mem_wr_t mem_wr
);
    import mlt_pkg::*;

    typedef enum logic [5:0] {
        M_IDLE  = 6'b000001,
        M_STR   = 6'b000010,
        M_NUM   = 6'b000100,
        M_IDENT = 6'b001000,
        M_EQ    = 6'b010000,
        M_ERR   = 6'b100000
    } mode_t;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    localparam logic [7:0] KW_PRINT [5] = '{8'h70, 8'h72, 8'h69, 8'h6E, 8'h74};
    localparam logic [7:0] KW_VAR   [3] = '{8'h76, 8'h61, 8'h72};
    localparam logic [7:0] KW_IF    [2] = '{8'h69, 8'h66};

    mode_t               mode_reg, mode_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic                ovf_reg, ovf_next;
    logic [2:0]          kw_reg, kw_next;        // print, var, if prefix hits
    logic                phase_reg, phase_next;  // first command already queued
    logic [TXT_CNT_W-1:0] txt_cnt_reg, txt_cnt_next;

    logic is_digit, is_alpha, is_space, is_quote, is_eq;
    logic op_hit;
    logic [TOK_W-1:0] op_kind;

    cmd_t  si_cmd, fl_cmd, eq_cmd, eol_cmd, a_cmd, b_cmd;
    logic  si_cmd_valid, si_app;
    mode_t si_mode;
    logic  fl_valid;

    logic  a_valid, b_valid, do_clear, do_app, restart;
    logic  step_done, accept;
    logic  [LEN_W-1:0] base_len;
    logic  room;
    logic  [2:0] kw_char_hit;

    // ---------------- byte classes ----------------
    always_comb
    begin
        is_digit = (byte_value >= 8'h30) && (byte_value <= 8'h39);
        is_alpha = ((byte_value >= 8'h61) && (byte_value <= 8'h7A)) ||
                   ((byte_value >= 8'h41) && (byte_value <= 8'h5A));
        is_space = (byte_value == 8'h20) ||
                   ((byte_value >= 8'h09) && (byte_value <= 8'h0D));
        is_quote = (byte_value == CH_QUOTE);
        is_eq    = (byte_value == CH_EQ);

        op_hit  = 1'b1;
        op_kind = TOK_ERROR;
        unique case (byte_value)
            8'h2B:   op_kind = TOK_PLUS;
            8'h2D:   op_kind = TOK_MINUS;
            8'h2A:   op_kind = TOK_MUL;
            8'h2F:   op_kind = TOK_DIV;
            8'h28:   op_kind = TOK_LPAREN;
            8'h29:   op_kind = TOK_RPAREN;
            8'h3B:   op_kind = TOK_SEMI;
            8'h3A:   op_kind = TOK_COLON;
            default: op_hit  = 1'b0;
        endcase
    end

    // ---------------- command candidates ----------------
    always_comb
    begin
        // byte scanned from idle
        si_cmd            = '0;
        si_cmd.kind       = op_hit ? op_kind : TOK_ERROR;
        si_cmd.ch         = byte_value;
        si_cmd.has_char   = 1'b1;
        si_cmd.token_last = 1'b1;
        si_cmd_valid      = !(is_quote || is_space || is_digit || is_alpha || is_eq);
        si_app            = is_digit || is_alpha;
        if (is_quote)
            si_mode = M_STR;
        else if (is_digit)
            si_mode = M_NUM;
        else if (is_alpha)
            si_mode = M_IDENT;
        else if (is_eq)
            si_mode = M_EQ;
        else if (is_space || op_hit)
            si_mode = M_IDLE;
        else
            si_mode = M_ERR;

        eq_cmd            = '0;
        eq_cmd.ch         = CH_EQ;
        eq_cmd.has_char   = 1'b1;
        eq_cmd.token_last = 1'b1;
        eq_cmd.kind       = TOK_RECEIVES;

        eol_cmd            = '0;
        eol_cmd.kind       = TOK_EOL;
        eol_cmd.token_last = 1'b1;

        // pending token
        fl_cmd            = '0;
        fl_cmd.is_text    = 1'b1;
        fl_cmd.token_last = 1'b1;
        fl_cmd.ovf        = ovf_reg;
        fl_cmd.len        = len_reg;
        fl_valid          = 1'b0;
        unique case (mode_reg)
            M_STR:
            begin
                fl_valid    = 1'b1;
                fl_cmd.kind = TOK_STRING;
            end
            M_NUM:
            begin
                fl_valid    = 1'b1;
                fl_cmd.kind = TOK_NUMBER;
            end
            M_IDENT:
            begin
                // an overflowed or other identifier is dropped
                if (!ovf_reg && kw_reg[2] && len_reg == LEN_W'(5))
                begin
                    fl_valid    = 1'b1;
                    fl_cmd.kind = TOK_PRINT;
                end
                else if (!ovf_reg && kw_reg[1] && len_reg == LEN_W'(3))
                begin
                    fl_valid    = 1'b1;
                    fl_cmd.kind = TOK_VAR;
                end
                else if (!ovf_reg && kw_reg[0] && len_reg == LEN_W'(2))
                begin
                    fl_valid    = 1'b1;
                    fl_cmd.kind = TOK_IF;
                end
            end
            M_EQ:
            begin
                fl_valid = 1'b1;
                fl_cmd   = eq_cmd;
            end
            M_IDLE, M_ERR:
            begin
                fl_valid = 1'b0;
            end
            default:
            begin
                fl_valid = 1'b0;
            end
        endcase
    end

    // ---------------- per-byte plan ----------------
    always_comb
    begin
        a_valid   = 1'b0;
        a_cmd     = fl_cmd;
        b_valid   = 1'b0;
        b_cmd     = si_cmd;
        do_clear  = 1'b0;
        do_app    = 1'b0;
        restart   = 1'b0;
        mode_next = mode_reg;

        if (line_end)
        begin
            a_valid   = fl_valid;
            b_valid   = 1'b1;
            b_cmd     = eol_cmd;
            do_clear  = 1'b1;
            mode_next = M_IDLE;
        end
        else
        begin
            unique case (mode_reg)
                M_IDLE:
                begin
                    restart = 1'b1;
                end
                M_STR:
                begin
                    if (is_quote)
                    begin
                        a_valid   = 1'b1;
                        do_clear  = 1'b1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        do_app = 1'b1;
                    end
                end
                M_NUM:
                begin
                    if (is_digit)
                        do_app = 1'b1;
                    else
                        restart = 1'b1;
                end
                M_IDENT:
                begin
                    if (is_digit || is_alpha || byte_value == CH_UNDER)
                        do_app = 1'b1;
                    else
                        restart = 1'b1;
                end
                M_EQ:
                begin
                    if (is_eq)
                    begin
                        a_valid          = 1'b1;
                        a_cmd            = eq_cmd;
                        a_cmd.kind       = TOK_EQUALITY;
                        a_cmd.token_last = 1'b0;
                        b_valid          = 1'b1;
                        b_cmd            = eq_cmd;
                        b_cmd.kind       = TOK_EQUALITY;
                        mode_next        = M_IDLE;
                    end
                    else
                    begin
                        restart = 1'b1;
                    end
                end
                M_ERR:
                begin
                    mode_next = M_ERR;
                end
                default:
                begin
                    mode_next = M_IDLE;
                end
            endcase

            // flush whatever is pending, then scan the byte from idle
            if (restart)
            begin
                a_valid   = fl_valid;
                b_valid   = si_cmd_valid;
                do_clear  = 1'b1;
                do_app    = si_app;
                mode_next = si_mode;
            end
        end

        a_cmd.run_last = !b_valid;
        b_cmd.run_last = 1'b1;
    end

    // ---------------- step control ----------------
    always_comb
    begin
        push       = 1'b0;
        push_cmd   = b_cmd;
        step_done  = 1'b0;
        phase_next = phase_reg;

        if (!a_valid || phase_reg)
        begin
            // buffer writes wait until the emitter has read out older text
            step_done = (!b_valid || !q_full) && (!do_app || txt_cnt_reg == '0);
            push      = in_valid && b_valid && step_done;
        end
        else
        begin
            push      = in_valid && !q_full;
            push_cmd  = a_cmd;
            step_done = !q_full && !b_valid && !do_app;
            if (push && !step_done)
                phase_next = 1'b1;
        end

        accept = in_valid && step_done;
        if (accept)
            phase_next = 1'b0;
    end

    assign in_stall = !step_done;

    // ---------------- token text ----------------
    always_comb
    begin
        base_len = do_clear ? '0 : len_reg;
        room     = (base_len < LEN_W'(MAX_TOKEN_CHARS));

        kw_char_hit[2] = (base_len < LEN_W'(5)) && (byte_value == KW_PRINT[base_len[2:0]]);
        kw_char_hit[1] = (base_len < LEN_W'(3)) && (byte_value == KW_VAR[base_len[1:0]]);
        kw_char_hit[0] = (base_len < LEN_W'(2)) && (byte_value == KW_IF[base_len[0]]);

        len_next = base_len;
        ovf_next = do_clear ? 1'b0 : ovf_reg;
        kw_next  = kw_reg;
        if (do_app)
        begin
            if (room)
                len_next = base_len + LEN_W'(1);
            else
                ovf_next = 1'b1;
            kw_next = ((base_len == '0) ? 3'b111 : kw_reg) & kw_char_hit;
        end

        mem_wr.en   = accept && do_app && room;
        mem_wr.addr = base_len[IDX_W-1:0];
        mem_wr.data = byte_value;

        txt_cnt_next = txt_cnt_reg + TXT_CNT_W'(push && push_cmd.is_text)
                                   - TXT_CNT_W'(text_done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= M_IDLE;
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            kw_reg      <= '0;
            phase_reg   <= 1'b0;
            txt_cnt_reg <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            txt_cnt_reg <= txt_cnt_next;
            if (accept)
            begin
                mode_reg <= mode_next;
                len_reg  <= len_next;
                ovf_reg  <= ovf_next;
                kw_reg   <= kw_next;
            end
        end
    end

endmodule

FILE: rtl/core/mlt_back.sv
// ----------------------------------------------------------------------------
// mlt_back
// Emitter: owns the text buffer, takes commands from the queue and plays
// them out as result beats through a registered output.
// ----------------------------------------------------------------------------
module mlt_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_empty,
    input  mlt_pkg::cmd_t            q_head,
    output logic                     pop,
    output logic                     text_done,
    input  mlt_pkg::mem_wr_t         mem_wr,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [mlt_pkg::TOK_W-1:0] token_kind,
    output logic [7:0]               char_value,
    output logic                     has_char,
    output logic                     token_last,
    output logic                     run_last,
    output logic                     overflow
);
    import mlt_pkg::*;

    typedef enum logic [2:0] {
        BK_IDLE  = 3'b001,
        BK_FETCH = 3'b010,
        BK_EMIT  = 3'b100
    } bk_state_t;

    logic [7:0]       text_mem [MAX_TOKEN_CHARS];
    logic [7:0]       rdata_reg;

    bk_state_t        state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [IDX_W-1:0] pos_reg, pos_next;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [LEN_W-1:0] pos_inc, pos_inc2;
    logic             text_mode, is_last, out_free, load;

    logic             out_valid_reg, out_valid_next;
    logic [TOK_W-1:0] kind_reg, kind_next;
    logic [7:0]       ch_reg, ch_next;
    logic             has_reg, has_next;
    logic             tlast_reg, tlast_next;
    logic             rlast_reg, rlast_next;
    logic             ovf_reg, ovf_next;

    always_comb
    begin
        pos_inc   = LEN_W'(pos_reg) + LEN_W'(1);
        pos_inc2  = pos_inc + LEN_W'(1);
        text_mode = cmd_reg.is_text && (cmd_reg.len != '0);
        is_last   = (pos_inc == cmd_reg.len);
        out_free  = !out_valid_reg || !out_stall;

        state_next = state_reg;
        cmd_next   = cmd_reg;
        pos_next   = pos_reg;
        pop        = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = pos_reg;
        text_done  = 1'b0;
        load       = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    cmd_next = q_head;
                    pos_next = '0;
                    if (q_head.is_text && q_head.len != '0)
                        state_next = BK_FETCH;
                    else
                    begin
                        state_next = BK_EMIT;
                        text_done  = q_head.is_text;
                    end
                end
            end
            BK_FETCH:
            begin
                rd_en      = 1'b1;
                text_done  = (cmd_reg.len == LEN_W'(1));
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    if (text_mode && !is_last)
                    begin
                        // prefetch the next character while this one leaves
                        rd_en     = 1'b1;
                        rd_addr   = pos_inc[IDX_W-1:0];
                        pos_next  = pos_inc[IDX_W-1:0];
                        text_done = (pos_inc2 == cmd_reg.len);
                    end
                    else
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        if (text_mode)
        begin
            kind_next  = cmd_reg.kind;
            ch_next    = rdata_reg;
            has_next   = 1'b1;
            tlast_next = is_last;
            rlast_next = cmd_reg.run_last && is_last;
            ovf_next   = cmd_reg.ovf;
        end
        else
        begin
            kind_next  = cmd_reg.kind;
            ch_next    = cmd_reg.ch;
            has_next   = cmd_reg.has_char;
            tlast_next = cmd_reg.token_last;
            rlast_next = cmd_reg.run_last;
            ovf_next   = cmd_reg.ovf;
        end

        if (load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
        begin
            text_mem[mem_wr.addr] <= mem_wr.data;
        end
        if (rd_en)
        begin
            rdata_reg <= text_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        pos_reg <= pos_next;
        if (load)
        begin
            kind_reg  <= kind_next;
            ch_reg    <= ch_next;
            has_reg   <= has_next;
            tlast_reg <= tlast_next;
            rlast_reg <= rlast_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign token_kind = kind_reg;
    assign char_value = ch_reg;
    assign has_char   = has_reg;
    assign token_last = tlast_reg;
    assign run_last   = rlast_reg;
    assign overflow   = ovf_reg;

endmodule

FILE: rtl/core/mini_language_tokenizer.sv
// ----------------------------------------------------------------------------
// mini_language_tokenizer
// Line tokenizer for a small scripting language: bytes in, one result
// beat per token character out.
// ----------------------------------------------------------------------------
// Each input beat carries one byte of a line, or a line end. Whitespace is
// skipped; strings, numbers and identifiers are collected in a 32-entry
// text buffer and played out, one beat per character, once the token ends.
// Only print, var and if survive of the identifiers; operators, "=", "=="
// and end_of_line give beats of their own, and a bad byte gives error and
// mutes the rest of the line. run_last marks the final beat caused by an
// input beat. Timing: a byte that only extends a token or is whitespace
// is taken without a stall unless it has to write the buffer. A byte
// that closes a token and starts another result is held while its two
// commands are queued, the closing one first. A byte that has to write
// the buffer waits until the emitter has fetched all text of earlier
// tokens; the emitter picks up a command in its idle state and primes
// the buffer read in its fetch state, then sends one character per
// cycle while the consumer does not stall. A two-entry command queue
// lets the scanner run ahead on bytes that make single-beat results
// while text is still going out. Results wait in an output register,
// so a stalled consumer does not stop the scanner until the queue fills.
// ----------------------------------------------------------------------------
module mini_language_tokenizer (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                byte_value,
    input  logic                      line_end,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [mlt_pkg::TOK_W-1:0] token_kind,
    output logic [7:0]                char_value,
    output logic                      has_char,
    output logic                      token_last,
    output logic                      run_last,
    output logic                      overflow
);
    import mlt_pkg::*;

    // scanner -> queue
    logic    push;
    cmd_t    push_cmd;
    logic    q_full;

    // queue -> emitter
    cmd_t    q_head;
    logic    q_empty;
    logic    pop;

    // emitter tells the scanner when a token's text has been read out
    logic    text_done;

    // buffer writes come from the scanner, the buffer lives in the emitter
    mem_wr_t mem_wr;

    mlt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_value (byte_value),
        .line_end   (line_end),
        .push       (push),
        .push_cmd   (push_cmd),
        .q_full     (q_full),
        .text_done  (text_done),
        .mem_wr     (mem_wr)
    );

    mlt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    mlt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .pop        (pop),
        .text_done  (text_done),
        .mem_wr     (mem_wr),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .token_kind (token_kind),
        .char_value (char_value),
        .has_char   (has_char),
        .token_last (token_last),
        .run_last   (run_last),
        .overflow   (overflow)
    );

endmodule

FILE: rtl/core/mlt_checker.sv
// ----------------------------------------------------------------------------
// mlt_checker
// Port-level checks on the tokenizer's result channel.
// ----------------------------------------------------------------------------
`include "mini_language_tokenizer_macros.svh"

module mlt_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [mlt_pkg::TOK_W-1:0] token_kind,
    input logic [7:0]                char_value,
    input logic                      has_char,
    input logic                      token_last,
    input logic                      run_last,
    input logic                      overflow
);
    import mlt_pkg::*;

    // a stalled result beat holds
    `MLT_ASSERT_NXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(token_kind) && $stable(char_value) && $stable(has_char)
        && $stable(token_last) && $stable(run_last) && $stable(overflow),
        "result beat changed while stalled")

    // the last beat of an input beat always closes a token
    `MLT_ASSERT_IMP(a_run_closes_token, out_valid && run_last, token_last,
        "run_last without token_last")

    // end of line is a bare, final beat
    `MLT_ASSERT_IMP(a_eol_shape, out_valid && token_kind == TOK_EOL,
        run_last && token_last && !has_char && !overflow,
        "malformed end_of_line beat")

    // error carries the bad byte and ends the run
    `MLT_ASSERT_IMP(a_error_shape, out_valid && token_kind == TOK_ERROR,
        run_last && token_last && has_char && !overflow,
        "malformed error beat")

    // only text tokens may report truncation
    `MLT_ASSERT_IMP(a_ovf_text_only, out_valid && overflow,
        token_kind == TOK_STRING || token_kind == TOK_NUMBER,
        "overflow on a non-text token")

endmodule

bind mini_language_tokenizer mlt_checker u_mlt_checker (.*);

FILE: dv/mini_language_tokenizer_checker.sv
// ----------------------------------------------------------------------------
// mini_language_tokenizer_checker
// Watches the byte and token channels of the tokenizer. It keeps its own
// copy of the lexer state and turns each accepted byte beat into the token
// beats it should produce. Each accepted token beat is compared field by
// field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module mini_language_tokenizer_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_stall,
    input  logic [7:0]                byte_value,
    input  logic                      line_end,
    input  logic                      out_valid,
    input  logic                      out_stall,
    input  logic [mlt_pkg::TOK_W-1:0] token_kind,
    input  logic [7:0]                char_value,
    input  logic                      has_char,
    input  logic                      token_last,
    input  logic                      run_last,
    input  logic                      overflow,
    output int                        fail_count,
    output int                        pending,
    output int                        results_checked
);

    import mlt_pkg::*;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_STRING,
        SCAN_NUMBER,
        SCAN_WORD,
        SCAN_EQUALS,
        SCAN_MUTED
    } scan_mode_t;

    typedef struct packed {
        logic [TOK_W-1:0] kind;
        logic [7:0]       ch;
        logic             has;
        logic             tok_end;
        logic             run_end;
        logic             ovf;
    } token_beat_t;

    scan_mode_t  mode;
    logic [7:0]  text_buf [MAX_TOKEN_CHARS];
    int          text_len;
    logic        text_ovf;

    token_beat_t step_beats[$];       // beats of the byte being lexed
    token_beat_t token_beats_due[$];  // beats not yet seen on the output

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic word_is(input string w);
        if (text_ovf || text_len != w.len())
            return 1'b0;
        for (int i = 0; i < text_len; i++)
            if (text_buf[i] != w[i])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic put_beat(input logic [TOK_W-1:0] kind, input logic [7:0] ch,
                            input logic has, input logic tok_end, input logic ovf);
        token_beat_t b;
        b.kind    = kind;
        b.ch      = ch;
        b.has     = has;
        b.tok_end = tok_end;
        b.run_end = 1'b0;
        b.ovf     = ovf;
        step_beats.insert(step_beats.size(), b);
    endtask

    task automatic clear_text();
        text_len = 0;
        text_ovf = 1'b0;
    endtask

    // Characters past the buffer are dropped and flag the token.
    task automatic keep_char(input logic [7:0] b);
        if (text_len < MAX_TOKEN_CHARS)
        begin
            text_buf[text_len] = b;
            text_len++;
        end
        else
        begin
            text_ovf = 1'b1;
        end
    endtask

    task automatic play_text(input logic [TOK_W-1:0] kind);
        if (text_len == 0)
            put_beat(kind, 8'h00, 1'b0, 1'b1, text_ovf);
        else
            for (int i = 0; i < text_len; i++)
                put_beat(kind, text_buf[i], 1'b1, i == text_len - 1, text_ovf);
    endtask

    task automatic close_token();
        case (mode)
            SCAN_STRING: play_text(TOK_STRING);
            SCAN_NUMBER: play_text(TOK_NUMBER);
            SCAN_WORD:
            begin
                if (word_is("print"))
                    play_text(TOK_PRINT);
                else if (word_is("var"))
                    play_text(TOK_VAR);
                else if (word_is("if"))
                    play_text(TOK_IF);
            end
            SCAN_EQUALS: put_beat(TOK_RECEIVES, "=", 1'b1, 1'b1, 1'b0);
            default: ;
        endcase
        mode = SCAN_IDLE;
        clear_text();
    endtask

    task automatic scan_fresh(input logic [7:0] b);
        logic [TOK_W-1:0] op;
        if (b == "\"")
        begin
            mode = SCAN_STRING;
            clear_text();
        end
        else if (is_blank(b))
        begin
        end
        else if (is_digit(b))
        begin
            mode = SCAN_NUMBER;
            clear_text();
            keep_char(b);
        end
        else if (is_letter(b))
        begin
            mode = SCAN_WORD;
            clear_text();
            keep_char(b);
        end
        else if (b == "=")
        begin
            mode = SCAN_EQUALS;
        end
        else
        begin
            case (b)
                "+":     op = TOK_PLUS;
                "-":     op = TOK_MINUS;
                "*":     op = TOK_MUL;
                "/":     op = TOK_DIV;
                "(":     op = TOK_LPAREN;
                ")":     op = TOK_RPAREN;
                ";":     op = TOK_SEMI;
                ":":     op = TOK_COLON;
                default: op = TOK_ERROR;
            endcase
            if (op == TOK_ERROR)
            begin
                mode = SCAN_MUTED;
                clear_text();
            end
            put_beat(op, b, 1'b1, 1'b1, 1'b0);
        end
    endtask

    task automatic lex_byte(input logic [7:0] b, input logic eol);
        token_beat_t t;
        step_beats.delete();
        if (eol)
        begin
            // a muted line only reports its end
            if (mode == SCAN_MUTED)
            begin
                mode = SCAN_IDLE;
                clear_text();
            end
            else
            begin
                close_token();
            end
            put_beat(TOK_EOL, 8'h00, 1'b0, 1'b1, 1'b0);
        end
        else
        begin
            case (mode)
                SCAN_STRING:
                begin
                    if (b == "\"")
                        close_token();
                    else
                        keep_char(b);
                end
                SCAN_NUMBER:
                begin
                    if (is_digit(b))
                    begin
                        keep_char(b);
                    end
                    else
                    begin
                        close_token();
                        scan_fresh(b);
                    end
                end
                SCAN_WORD:
                begin
                    if (is_letter(b) || is_digit(b) || b == "_")
                    begin
                        keep_char(b);
                    end
                    else
                    begin
                        close_token();
                        scan_fresh(b);
                    end
                end
                SCAN_EQUALS:
                begin
                    if (b == "=")
                    begin
                        put_beat(TOK_EQUALITY, "=", 1'b1, 1'b0, 1'b0);
                        put_beat(TOK_EQUALITY, "=", 1'b1, 1'b1, 1'b0);
                        mode = SCAN_IDLE;
                    end
                    else
                    begin
                        // lone '=': the byte after it is scanned, not skipped
                        close_token();
                        scan_fresh(b);
                    end
                end
                SCAN_MUTED: ;
                default: scan_fresh(b);
            endcase
        end
        for (int i = 0; i < step_beats.size(); i++)
        begin
            t = step_beats[i];
            t.run_end = (i == step_beats.size() - 1);
            token_beats_due.insert(token_beats_due.size(), t);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] due_v,
                               input logic [7:0] got_v);
        if (got_v !== due_v)
        begin
            $error("%s: expected %0d, got %0d", name, due_v, got_v);
            fail_count++;
        end
    endtask

    task automatic check_beat();
        token_beat_t d;
        results_checked++;
        if (token_beats_due.size() == 0)
        begin
            $error("token beat with nothing outstanding: token_kind %0d char_value 0x%02h",
                   token_kind, char_value);
            fail_count++;
        end
        else
        begin
            d = token_beats_due.pop_front();
            check_field("token_kind", 8'(d.kind), 8'(token_kind));
            check_field("char_value", d.ch, char_value);
            check_field("has_char", 8'(d.has), 8'(has_char));
            check_field("token_last", 8'(d.tok_end), 8'(token_last));
            check_field("run_last", 8'(d.run_end), 8'(run_last));
            check_field("overflow", 8'(d.ovf), 8'(overflow));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode = SCAN_IDLE;
            clear_text();
            token_beats_due.delete();
            pending <= 0;
        end
        else
        begin
            // output first: a token beat never stems from a byte taken at the same edge
            if (out_valid === 1'b1 && out_stall === 1'b0)
                check_beat();
            if (in_valid === 1'b1 && in_stall === 1'b0)
                lex_byte(byte_value, line_end);
            pending <= token_beats_due.size();
        end
    end

endmodule

FILE: dv/mini_language_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// mini_language_tokenizer_tb
// Regression bench for the line tokenizer. A short hand-written set of
// lines covers every operator, keyword handling, the empty and the
// unterminated string, "=" against "==" and a bad byte. Then random lines
// of well-formed tokens with some noise follow, including tokens at and
// past the text buffer size. A checker beside the block predicts and
// compares every token beat. Both sides idle at random; there is one long
// hold on the output and regular pauses until all results are in.
// ----------------------------------------------------------------------------
module mini_language_tokenizer_tb;

    import mlt_pkg::*;

    localparam int RANDOM_ITEMS   = 190;   // byte beats in the random part
    localparam int RX_HOLD_CYCLES = 300;   // the one long output hold
    localparam int TAIL_CYCLES    = 80;    // longest token plus emitter overhead
    localparam int STUCK_LIMIT    = 4000;  // cycles with no beat on either side

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             in_valid   = 1'b0;
    logic             in_stall;
    logic [7:0]       byte_value = 8'h00;
    logic             line_end   = 1'b0;
    logic             out_valid;
    logic             out_stall  = 1'b0;
    logic [TOK_W-1:0] token_kind;
    logic [7:0]       char_value;
    logic             has_char;
    logic             token_last;
    logic             run_last;
    logic             overflow;

    int fail_count;
    int pending;
    int results_checked;

    // stimulus side flags read by the result sink
    logic steady    = 1'b0;   // no idling on either side
    logic hold_req  = 1'b0;   // ask the sink for its long hold
    logic hold_done = 1'b0;

    int beats_sent     = 0;
    int lines_sent     = 0;
    int directed_beats = 0;
    int stuck_cycles   = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    mini_language_tokenizer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_value (byte_value),
        .line_end   (line_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .token_kind (token_kind),
        .char_value (char_value),
        .has_char   (has_char),
        .token_last (token_last),
        .run_last   (run_last),
        .overflow   (overflow)
    );

    mini_language_tokenizer_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .byte_value      (byte_value),
        .line_end        (line_end),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .token_kind      (token_kind),
        .char_value      (char_value),
        .has_char        (has_char),
        .token_last      (token_last),
        .run_last        (run_last),
        .overflow        (overflow),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked)
    );

    // Idle length for either side: mostly none, often a few cycles,
    // now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Byte channel driver. Values change only at a rising edge; valid is
    // kept high straight into the next beat when there is no gap, so it
    // is never dropped and raised in the same step. The stall sampled at
    // the edge decides acceptance.
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [7:0] b, input logic eol);
        int gap;
        gap = steady ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        byte_value <= b;
        line_end   <= eol;
        do @(posedge clk); while (in_stall !== 1'b0);
        beats_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
    endtask

    // byte_value is don't-care on a line end, so it carries random data
    task automatic end_line();
        send_beat(8'($urandom_range(0, 255)), 1'b1);
        lines_sent++;
    endtask

    // Valid goes low, then wait for the checker to report nothing
    // outstanding (its count is registered, so it trails the edge).
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [7:0] string_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == "\"");
        return c;
    endfunction

    function automatic logic [7:0] word_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 8'($urandom_range("a", "z"));
        if (r < 6)
            return 8'($urandom_range("A", "Z"));
        if (r < 9)
            return 8'($urandom_range("0", "9"));
        return "_";
    endfunction

    // shape: 0 string, 1 number, 2 identifier; len counts the token text
    task automatic send_long_token(input int shape, input int len);
        if (shape == 0)
        begin
            send_beat("\"", 1'b0);
            repeat (len) send_beat(string_byte(), 1'b0);
            send_beat("\"", 1'b0);
        end
        else if (shape == 1)
        begin
            repeat (len) send_beat(8'($urandom_range("0", "9")), 1'b0);
            send_beat(" ", 1'b0);
        end
        else
        begin
            send_beat(8'($urandom_range("a", "z")), 1'b0);
            repeat (len - 1) send_beat(word_char(), 1'b0);
            send_beat(" ", 1'b0);
        end
    endtask

    // One random token, mostly well formed. Keywords and identifiers are
    // sometimes, and numbers always, butted against the next token so the
    // token-end path gets hit as well as plain whitespace.
    task automatic send_random_token();
        int    pick;
        int    r;
        string ops;
        string junk;
        ops  = "+-*/();:";
        junk = "!#$%&',.<>?@[]^{|}~\\";
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            r = $urandom_range(0, 2);
            if (r == 0)
                send_text("print");
            else if (r == 1)
                send_text("var");
            else
                send_text("if");
            if ($urandom_range(0, 1))
                send_beat(" ", 1'b0);
        end
        else if (pick < 24)
        begin
            send_beat($urandom_range(0, 1) ? 8'($urandom_range("a", "z"))
                                           : 8'($urandom_range("A", "Z")), 1'b0);
            repeat ($urandom_range(0, 6)) send_beat(word_char(), 1'b0);
            if ($urandom_range(0, 1))
                send_beat(" ", 1'b0);
        end
        else if (pick < 38)
        begin
            repeat ($urandom_range(1, 5)) send_beat(8'($urandom_range("0", "9")), 1'b0);
        end
        else if (pick < 52)
        begin
            send_beat("\"", 1'b0);
            repeat ($urandom_range(0, 8)) send_beat(string_byte(), 1'b0);
            // an unclosed string swallows the rest of the line
            if ($urandom_range(0, 9) != 0)
                send_beat("\"", 1'b0);
        end
        else if (pick < 70)
        begin
            send_beat(ops[$urandom_range(0, ops.len() - 1)], 1'b0);
        end
        else if (pick < 80)
        begin
            send_beat("=", 1'b0);
            if ($urandom_range(0, 1))
                send_beat("=", 1'b0);
        end
        else if (pick < 90)
        begin
            r = $urandom_range(8, 13);
            send_beat(r == 8 ? " " : 8'(r), 1'b0);
        end
        else if (pick < 95)
        begin
            // bad byte: mutes the rest of the line
            if ($urandom_range(0, 1))
                send_beat(8'($urandom_range(128, 255)), 1'b0);
            else
                send_beat(junk[$urandom_range(0, junk.len() - 1)], 1'b0);
        end
        else
        begin
            r = $urandom_range(0, 3);
            send_long_token($urandom_range(0, 2),
                            r == 0 ? 31 : r == 1 ? 32 : r == 2 ? 33 : $urandom_range(34, 40));
        end
    endtask

    // ------------------------------------------------------------------
    // Token sink: random stalls of mixed length, none while the steady
    // flag is up, plus one long hold on request. The hold is counted
    // here, so the byte side keeps offering beats until the block backs
    // up and stalls its input.
    // ------------------------------------------------------------------
    initial
    begin : token_sink
        int run;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                run = steady ? 0 : idle_len();
                if (run > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (run) @(posedge clk);
                end
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // Watchdog: a run with no beat moving on either side for too long is hung.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            stuck_cycles <= 0;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("mini_language_tokenizer regression: fail");
                $finish;
            end
        end
    end

    initial
    begin : byte_source
        int line_no;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed lines ---
        // print ended by a quote, empty string, "==" then a lone "=" that
        // hands its next byte on to a number, every single-char operator,
        // then a bad byte (top value) and a discarded byte (bottom value)
        send_text("print\"\"===7+-*/();:");
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        end_line();
        // "if" closed by "=", and "=" flushed as receives by the line end
        send_text("if=");
        end_line();
        // unterminated empty string flushed at line end
        send_beat("\"", 1'b0);
        end_line();
        directed_beats = beats_sent;

        // --- random lines ---
        line_no = 0;
        while (beats_sent - directed_beats < RANDOM_ITEMS)
        begin
            if (line_no == 2)
                hold_req <= 1'b1;
            steady <= (line_no >= 4 && line_no < 6);
            if (line_no % 3 == 1)
                wait_drained();
            // buffer size exactly, one past it, and two past it
            if (line_no == 0)
                send_long_token(0, MAX_TOKEN_CHARS);
            else if (line_no == 1)
                send_long_token(1, MAX_TOKEN_CHARS + 1);
            else if (line_no == 3)
                send_long_token(2, MAX_TOKEN_CHARS + 2);
            repeat ($urandom_range(1, 6)) send_random_token();
            end_line();
            line_no++;
        end

        wait_drained();
        // let any late, unexpected beat show up before the verdict
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d byte beats (%0d directed) over %0d lines, %0d token beats checked",
                 beats_sent, directed_beats, lines_sent, results_checked);
        $display("included buffer-size and overflowed tokens, bad bytes and a %0d-cycle hold",
                 RX_HOLD_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("mini_language_tokenizer regression: pass");
        else
            $display("mini_language_tokenizer regression: fail");
        $finish;
    end

endmodule

FILE: mini_language_tokenizer.f
+incdir+rtl/core
rtl/core/mlt_pkg.sv
rtl/core/mlt_queue.sv
rtl/core/mlt_front.sv
rtl/core/mlt_back.sv
rtl/core/mini_language_tokenizer.sv
rtl/core/mlt_checker.sv
dv/mini_language_tokenizer_checker.sv
dv/mini_language_tokenizer_tb.sv
